// ----- design/clsr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package clsr_pkg;

	// default sizes of the list
	localparam int CAPACITY_DEF    = 8;
	localparam int HANDLE_BITS_DEF = 32;

	// fixed widths of the transfer fields
	localparam int OP_W     = 3;
	localparam int HANDLE_W = 32;
	localparam int COUNT_W  = 4;

	// operation codes, codes six and seven act as peek
	typedef enum logic [OP_W-1:0] {
		OP_PEEK     = 3'd0,
		OP_PUSH     = 3'd1,
		OP_REMOVE   = 3'd2,
		OP_NEXT     = 3'd3,
		OP_CYC_NEXT = 3'd4,
		OP_REWIND   = 3'd5
	} op_t;

	// one command transfer
	typedef struct packed {
		logic [OP_W-1:0]     operation;
		logic [HANDLE_W-1:0] handle;
	} cmd_t;

	// one result transfer
	typedef struct packed {
		logic [HANDLE_W-1:0] current_handle;
		logic                current_valid;
		logic                is_empty;
		logic                at_end;
		logic [COUNT_W-1:0]  entry_count;
		logic                overflow;
	} res_t;

endpackage

`default_nettype wire

// ----- design/cursor_list_swap_remove.sv -----
`timescale 1ns / 1ps
`default_nettype none

// an accepted command is captured in the input register, and its result and done
// are registered in the result register behind it
// throughput: one command per cycle; busy stays low, the list state updates on each accepted command
// the rate is set by the register file, read twice and written at most once per command
// the receiver cannot stall: done marks each result for a single cycle, and the result ports hold it until the next one
// reset (arst_n low, asynchronous) empties the list and rewinds the cursor

module cursor_list_swap_remove #(
	parameter int CAPACITY    = clsr_pkg::CAPACITY_DEF,
	parameter int HANDLE_BITS = clsr_pkg::HANDLE_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire clsr_pkg::cmd_t cmd,
	output logic                done,
	output clsr_pkg::res_t      result
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);

	logic                   valid_s1;
	clsr_pkg::cmd_t         cmd_s1;
	logic                   done_s2;
	clsr_pkg::res_t         result_s2;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       cursor_q;
	logic [CNT_W-1:0]       count_d;
	logic [CNT_W-1:0]       cursor_d;
	logic [IDX_W-1:0]       last_addr;
	logic [HANDLE_BITS-1:0] last_rd;
	logic [IDX_W-1:0]       cur_addr;
	logic [HANDLE_BITS-1:0] cur_rd;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	logic [HANDLE_BITS-1:0] wr_data;
	clsr_pkg::res_t         res;

	assign busy = 1'b0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
	end

	// list state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cursor_q <= '0;
			done_s2  <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
			if (valid_s1) begin
				count_q  <= count_d;
				cursor_q <= cursor_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= res;
		end
	end

	clsr_step #(
		.CAPACITY    (CAPACITY),
		.HANDLE_BITS (HANDLE_BITS)
	) u_step (
		.cmd       (cmd_s1),
		.count_q   (count_q),
		.cursor_q  (cursor_q),
		.last_addr (last_addr),
		.last_rd   (last_rd),
		.cur_addr  (cur_addr),
		.cur_rd    (cur_rd),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.count_d   (count_d),
		.cursor_d  (cursor_d),
		.res       (res)
	);

	clsr_regfile #(
		.DEPTH (CAPACITY),
		.WIDTH (HANDLE_BITS)
	) u_regfile (
		.clk       (clk),
		.wr_en     (wr_en && valid_s1),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (last_addr),
		.rd_data_a (last_rd),
		.rd_addr_b (cur_addr),
		.rd_data_b (cur_rd)
	);

	assign done   = done_s2;
	assign result = result_s2;

endmodule

`default_nettype wire

// ----- design/clsr_regfile.sv -----
`timescale 1ns / 1ps
`default_nettype none

module clsr_regfile #(
	parameter int DEPTH = clsr_pkg::CAPACITY_DEF,
	parameter int WIDTH = clsr_pkg::HANDLE_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
	output logic      [WIDTH-1:0]         rd_data_a,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic      [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port, contents undefined until written
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// two asynchronous read ports
	assign rd_data_a = mem_q[rd_addr_a];
	assign rd_data_b = mem_q[rd_addr_b];

endmodule

`default_nettype wire

// ----- design/clsr_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

module clsr_step #(
	parameter int CAPACITY    = clsr_pkg::CAPACITY_DEF,
	parameter int HANDLE_BITS = clsr_pkg::HANDLE_BITS_DEF,
	localparam int CNT_W      = $clog2(CAPACITY + 1),
	localparam int IDX_W      = $clog2(CAPACITY)
) (
	input  wire clsr_pkg::cmd_t         cmd,
	input  wire logic [CNT_W-1:0]       count_q,
	input  wire logic [CNT_W-1:0]       cursor_q,
	output logic      [IDX_W-1:0]       last_addr,
	input  wire logic [HANDLE_BITS-1:0] last_rd,
	output logic      [IDX_W-1:0]       cur_addr,
	input  wire logic [HANDLE_BITS-1:0] cur_rd,
	output logic                        wr_en,
	output logic      [IDX_W-1:0]       wr_addr,
	output logic      [HANDLE_BITS-1:0] wr_data,
	output logic      [CNT_W-1:0]       count_d,
	output logic      [CNT_W-1:0]       cursor_d,
	output clsr_pkg::res_t              res
);

	localparam int HW_W  = (HANDLE_BITS > clsr_pkg::HANDLE_W) ? HANDLE_BITS : clsr_pkg::HANDLE_W;
	localparam int CW_W  = (CNT_W > clsr_pkg::COUNT_W) ? CNT_W : clsr_pkg::COUNT_W;

	logic [HW_W-1:0]        handle_wide;
	logic [HW_W-1:0]        cur_wide;
	logic [CW_W-1:0]        count_wide;
	logic [HANDLE_BITS-1:0] handle_in;
	logic [HANDLE_BITS-1:0] cur_val;
	logic [CNT_W:0]         cursor_inc;
	logic [CNT_W-1:0]       count_m1;
	logic                   overflow;
	logic                   valid;
	logic                   fwd;

	// handle resized to the stored width
	assign handle_wide = HW_W'(cmd.handle);
	assign handle_in   = handle_wide[HANDLE_BITS-1:0];
	assign cursor_inc  = {1'b0, cursor_q} + (CNT_W + 1)'(1);

	// slot of the last stored entry
	assign count_m1    = count_q - CNT_W'(1);
	assign last_addr   = count_m1[IDX_W-1:0];

	// next list state and write port for one operation
	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = count_q[IDX_W-1:0];
		wr_data  = handle_in;
		count_d  = count_q;
		cursor_d = cursor_q;
		overflow = 1'b0;
		unique case (clsr_pkg::op_t'(cmd.operation))
			clsr_pkg::OP_PUSH: begin
				if (count_q < CNT_W'(CAPACITY)) begin
					wr_en   = 1'b1;
					count_d = count_q + CNT_W'(1);
				end else begin
					overflow = 1'b1;
				end
			end
			clsr_pkg::OP_REMOVE: begin
				// last entry moves into the slot under the cursor
				if (cursor_q < count_q) begin
					wr_en   = 1'b1;
					wr_addr = cursor_q[IDX_W-1:0];
					wr_data = last_rd;
					count_d = count_q - CNT_W'(1);
				end
			end
			clsr_pkg::OP_NEXT: begin
				if (cursor_q < CNT_W'(CAPACITY)) begin
					cursor_d = cursor_inc[CNT_W-1:0];
				end
			end
			clsr_pkg::OP_CYC_NEXT: begin
				if (cursor_inc >= {1'b0, count_q}) begin
					cursor_d = '0;
				end else begin
					cursor_d = cursor_inc[CNT_W-1:0];
				end
			end
			clsr_pkg::OP_REWIND: begin
				cursor_d = '0;
			end
			default: begin
			end
		endcase
	end

	// entry under the new cursor, taking a same-cycle write into account
	assign cur_addr = cursor_d[IDX_W-1:0];
	assign valid    = cursor_d < count_d;
	assign fwd      = wr_en && (wr_addr == cur_addr);
	assign cur_val  = !valid ? '0 : (fwd ? wr_data : cur_rd);

	// result fields resized to the transfer widths
	assign cur_wide   = HW_W'(cur_val);
	assign count_wide = CW_W'(count_d);

	always_comb begin
		res.current_handle = cur_wide[clsr_pkg::HANDLE_W-1:0];
		res.current_valid  = valid;
		res.is_empty       = (count_d == '0);
		res.at_end         = !valid;
		res.entry_count    = count_wide[clsr_pkg::COUNT_W-1:0];
		res.overflow       = overflow;
	end

endmodule

`default_nettype wire

// ----- design/clsr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module clsr_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           start,
	input wire logic           busy,
	input wire clsr_pkg::cmd_t cmd,
	input wire logic           done,
	input wire clsr_pkg::res_t result
);

	// every accepted command gives a result, through the input and result registers
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("accepted command gave no result");

	// no result without an earlier accepted command
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a command");

	// back-to-back results move the count by at most one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(done) |->
			(result.entry_count == $past(result.entry_count)) ||
			(result.entry_count == $past(result.entry_count) + 4'd1) ||
			(result.entry_count == $past(result.entry_count) - 4'd1))
		else $error("count jumped by more than one");

	// a dropped push comes only from a push command
	a_overflow_push: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.overflow |-> $past(cmd.operation, 2) == clsr_pkg::OP_PUSH)
		else $error("overflow on an operation other than push");

	// flags agree with each other
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.current_valid != result.at_end) &&
			!(result.current_valid && result.is_empty))
		else $error("inconsistent cursor flags");

endmodule

bind cursor_list_swap_remove clsr_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.result (result)
);

`default_nettype wire
